// File: rtl/core/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Types and codes shared by the text console character engine modules.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // command codes of an input word
  localparam logic [1:0] CMD_PUT    = 2'd0;
  localparam logic [1:0] CMD_SETCUR = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  // control characters
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [6:0] col;
    logic [4:0] row;
  } tcce_in_t;

  typedef struct packed {
    logic [10:0] cursor_index;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
  } tcce_out_t;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_PUT_CHR,
    OP_PUT_BS,
    OP_PUT_CR,
    OP_PUT_LF,
    OP_SETCUR,
    OP_CLEAR,
    OP_READ
  } tcce_op_t;

  typedef struct packed {
    tcce_op_t   op;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [6:0] col;   // saturated
    logic [4:0] row;   // saturated
  } tcce_job_t;

  typedef enum logic [3:0] {
    BK_INIT,
    BK_IDLE,
    BK_EXEC,
    BK_BS_WR,
    BK_RD_WAIT,
    BK_SCR_CHK,
    BK_SCR_CP,
    BK_SCR_BLANK,
    BK_CLEAR,
    BK_DONE
  } tcce_bk_state_t;

endpackage

// File: rtl/core/tcce_fifo.sv
// ----------------------------------------------------------------------------
// tcce_fifo
// Small register queue with the oldest word shown on its output.
// ----------------------------------------------------------------------------
module tcce_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// File: rtl/core/tcce_front.sv
// ----------------------------------------------------------------------------
// tcce_front
// Takes input words, saturates coordinates and classifies put characters.
// ----------------------------------------------------------------------------
module tcce_front #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic               push,
  input  tcce_pkg::tcce_in_t in_data,
  output logic               full,
  input  logic               init_busy,
  input  logic               job_full,
  output logic               job_push,
  output tcce_pkg::tcce_job_t job
);
  import tcce_pkg::*;

  localparam logic [6:0] COL_MAX = 7'(COLS - 1);
  localparam logic [4:0] ROW_MAX = 5'(ROWS - 1);

  // no word is taken during the clearing pass after reset
  assign full     = job_full || init_busy;
  assign job_push = push && !full;

  always_comb begin
    job.char_code = in_data.char_code;
    job.attribute = in_data.attribute;
    job.col       = (in_data.col > COL_MAX) ? COL_MAX : in_data.col;
    job.row       = (in_data.row > ROW_MAX) ? ROW_MAX : in_data.row;
    case (in_data.cmd)
      CMD_PUT: begin
        case (in_data.char_code)
          CH_BACKSPACE: job.op = OP_PUT_BS;
          CH_RETURN:    job.op = OP_PUT_CR;
          CH_NEWLINE:   job.op = OP_PUT_LF;
          default:      job.op = OP_PUT_CHR;
        endcase
      end
      CMD_SETCUR: job.op = OP_SETCUR;
      CMD_CLEAR:  job.op = OP_CLEAR;
      default:    job.op = OP_READ;
    endcase
  end

endmodule

// File: rtl/core/tcce_back.sv
// ----------------------------------------------------------------------------
// tcce_back
// Executes classified operations on the cell store and the cursor.
// ----------------------------------------------------------------------------
module tcce_back #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_empty,
  input  tcce_pkg::tcce_job_t job,
  output logic                job_pop,
  output logic                init_busy,
  input  logic                res_full,
  output logic                res_push,
  output tcce_pkg::tcce_out_t res
);
  import tcce_pkg::*;

  localparam int CELLS = COLS * ROWS;
  localparam int IDX_W = $clog2(CELLS);
  localparam int COL_W = $clog2(COLS);
  localparam int ROW_W = $clog2(ROWS + 1);

  localparam logic [IDX_W-1:0] COLS_I    = IDX_W'(COLS);
  localparam logic [IDX_W-1:0] CP_LAST   = IDX_W'(COLS * (ROWS - 2) - 1);
  localparam logic [IDX_W-1:0] BL_FIRST  = IDX_W'(COLS * (ROWS - 2));
  localparam logic [IDX_W-1:0] BL_LAST   = IDX_W'(COLS * (ROWS - 1) - 1);
  localparam logic [IDX_W-1:0] CELL_LAST = IDX_W'(CELLS - 1);
  localparam logic [COL_W:0]   COL_END   = (COL_W + 1)'(COLS);
  localparam logic [ROW_W-1:0] ROW_SCR   = ROW_W'(ROWS - 1);

  // cell store: attribute high byte, character low byte
  logic [15:0]      mem [CELLS];
  logic [15:0]      rd_data_r;
  logic             we;
  logic [IDX_W-1:0] wa, ra;
  logic [15:0]      wd;

  tcce_bk_state_t   state_r, state_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  tcce_job_t        job_r, job_nxt;
  logic [7:0]       rch_r, rch_nxt;
  logic [7:0]       rat_r, rat_nxt;

  logic [IDX_W-1:0] cur_idx;
  logic [COL_W:0]   col_inc;

  assign cur_idx   = IDX_W'(row_r) * COLS_I + IDX_W'(col_r);
  assign col_inc   = {1'b0, col_r} + 1'b1;
  assign init_busy = (state_r == BK_INIT);

  assign res.cursor_index = 11'(cur_idx);
  assign res.cell_char    = rch_r;
  assign res.cell_attr    = rat_r;

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    job_nxt   = job_r;
    rch_nxt   = rch_r;
    rat_nxt   = rat_r;
    we        = 1'b0;
    wa        = cnt_r;
    wd        = {job_r.attribute, 8'h00};
    ra        = '0;
    job_pop   = 1'b0;
    res_push  = 1'b0;
    case (state_r)
      BK_INIT: begin
        we      = 1'b1;
        wd      = '0;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CELL_LAST) begin
          cnt_nxt   = '0;
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!job_empty) begin
          job_pop   = 1'b1;
          job_nxt   = job;
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        rch_nxt   = '0;
        rat_nxt   = '0;
        state_nxt = BK_SCR_CHK;
        case (job_r.op)
          OP_PUT_CHR: begin
            we = 1'b1;
            wa = cur_idx;
            wd = {job_r.attribute, job_r.char_code};
            if (col_inc == COL_END) begin
              col_nxt = '0;
              row_nxt = row_r + 1'b1;
            end else begin
              col_nxt = col_inc[COL_W-1:0];
            end
          end
          OP_PUT_BS: begin
            if (col_r != '0) begin
              col_nxt   = col_r - 1'b1;
              ra        = cur_idx - 1'b1;
              idx_nxt   = cur_idx - 1'b1;
              state_nxt = BK_BS_WR;
            end
          end
          OP_PUT_CR: begin
            col_nxt = '0;
          end
          OP_PUT_LF: begin
            col_nxt = '0;
            row_nxt = row_r + 1'b1;
          end
          OP_SETCUR: begin
            col_nxt   = job_r.col[COL_W-1:0];
            row_nxt   = ROW_W'(job_r.row);
            state_nxt = BK_DONE;
          end
          OP_CLEAR: begin
            col_nxt   = '0;
            row_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = BK_CLEAR;
          end
          default: begin
            ra        = IDX_W'(job_r.row) * COLS_I + IDX_W'(job_r.col);
            state_nxt = BK_RD_WAIT;
          end
        endcase
      end
      BK_BS_WR: begin
        // keep the attribute, blank the character
        we        = 1'b1;
        wa        = idx_r;
        wd        = {rd_data_r[15:8], 8'h00};
        state_nxt = BK_SCR_CHK;
      end
      BK_RD_WAIT: begin
        rch_nxt   = rd_data_r[7:0];
        rat_nxt   = rd_data_r[15:8];
        state_nxt = BK_DONE;
      end
      BK_SCR_CHK: begin
        if (row_r >= ROW_SCR) begin
          ra        = COLS_I;
          cnt_nxt   = '0;
          state_nxt = BK_SCR_CP;
        end else begin
          state_nxt = BK_DONE;
        end
      end
      BK_SCR_CP: begin
        // read runs one row ahead of the write
        we      = 1'b1;
        wd      = rd_data_r;
        ra      = IDX_W'(cnt_r + COLS_I + 1'b1);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CP_LAST) begin
          cnt_nxt   = BL_FIRST;
          state_nxt = BK_SCR_BLANK;
        end
      end
      BK_SCR_BLANK: begin
        we      = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == BL_LAST) begin
          row_nxt   = row_r - 1'b1;
          state_nxt = BK_DONE;
        end
      end
      BK_CLEAR: begin
        we      = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CELL_LAST) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_INIT;
      col_r   <= '0;
      row_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    job_r <= job_nxt;
    rch_r <= rch_nxt;
    rat_r <= rat_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[ra];
  end

endmodule

// File: rtl/core/text_console_character_engine_unit.sv
// ----------------------------------------------------------------------------
// text_console_character_engine_unit
// Text-mode console: character/attribute cell store, cursor and scrolling.
// ----------------------------------------------------------------------------
// One result word per input word. After reset a clearing pass writes all
// COLS*ROWS cells, one per cycle, with full held high. With the back part
// idle, a taken word leaves the job queue into BK_EXEC; a put that does
// not scroll then passes BK_SCR_CHK, a read cell BK_RD_WAIT, set cursor
// nothing more, and a backspace that steps back BK_BS_WR and BK_SCR_CHK
// (registered read of the cell store before the write), before BK_DONE
// pushes the result. Clear screen writes all COLS*ROWS cells in BK_CLEAR,
// and a put that scrolls moves or blanks COLS*(ROWS-1) cells in BK_SCR_CP
// and BK_SCR_BLANK, one cell per cycle. The back part works on one word
// at a time, passing through BK_IDLE between words and stalling while the
// result queue is full; the front keeps queueing into a two-entry queue.
module text_console_character_engine_unit #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tcce_pkg::tcce_in_t  in_data,
  output logic                full,
  input  logic                pop,
  output tcce_pkg::tcce_out_t out_data,
  output logic                empty
);
  import tcce_pkg::*;

  localparam int JOB_W = $bits(tcce_job_t);
  localparam int RES_W = $bits(tcce_out_t);

  logic      init_busy;
  logic      job_push, job_full, job_pop, job_empty;
  tcce_job_t job_in, job_out;
  logic      res_push, res_full;
  tcce_out_t res;

  tcce_front #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_front (
    .push      (push),
    .in_data   (in_data),
    .full      (full),
    .init_busy (init_busy),
    .job_full  (job_full),
    .job_push  (job_push),
    .job       (job_in)
  );

  tcce_fifo #(
    .W    (JOB_W),
    .DEPTH(2)
  ) u_job_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (job_push),
    .din  (job_in),
    .full (job_full),
    .pop  (job_pop),
    .dout (job_out),
    .empty(job_empty)
  );

  tcce_back #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_empty(job_empty),
    .job      (job_out),
    .job_pop  (job_pop),
    .init_busy(init_busy),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  tcce_fifo #(
    .W    (RES_W),
    .DEPTH(2)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .din  (res),
    .full (res_full),
    .pop  (pop),
    .dout (out_data),
    .empty(empty)
  );

endmodule
